@@ hw/rtl/wscg_pkg.sv @@
// ----------------------------------------------------------------------------
// wscg_pkg: shared types and constants for the sector count generator
// Transaction structs, sequencer states, mode codes and register indexes.
// ----------------------------------------------------------------------------
package wscg_pkg;

  // sector granularity
  localparam int unsigned SectorUnit = 8;

  // generator constants
  localparam logic [31:0] TEMPER_MASK = 32'hda44_2d24;
  localparam logic [31:0] SEED_STEP   = 32'd73;

  // divisor width covers the largest mode 8 slot count
  localparam int unsigned DivW = 14;

  // input actions
  localparam logic ACT_SEED = 1'b0;
  localparam logic ACT_DRAW = 1'b1;

  // distribution modes
  localparam logic [3:0] MODE_NONE   = 4'd0;
  localparam logic [3:0] MODE_MIX120 = 4'd1;
  localparam logic [3:0] MODE_SPAN57 = 4'd2;
  localparam logic [3:0] MODE_MIX336 = 4'd3;
  localparam logic [3:0] MODE_SPN121 = 4'd4;
  localparam logic [3:0] MODE_SPAN64 = 4'd5;
  localparam logic [3:0] MODE_SPN128 = 4'd6;
  localparam logic [3:0] MODE_POW35  = 4'd7;
  localparam logic [3:0] MODE_RANGE  = 4'd8;

  // configuration register indexes
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_MIN  = 2'd1;
  localparam logic [1:0] REG_MAX  = 2'd2;

  typedef struct packed {
    logic        action;
    logic [31:0] seed;
  } wscg_in_t;

  typedef struct packed {
    logic [31:0] rand_word;
    logic [15:0] sector_count;
    logic        range_error;
  } wscg_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_GET_A,
    ST_GET_C,
    ST_GET_E,
    ST_GET_F,
    ST_DIV,
    ST_MAP,
    ST_OUT
  } wscg_state_t;

endpackage

@@ hw/rtl/well512_sector_count_generator_unit.sv @@
// ----------------------------------------------------------------------------
// well512_sector_count_generator_unit: WELL512 draws mapped to sector counts
// A draw makes 4 pool memory reads, then 32 steps of the shared restoring
// divider, map and output; a seed writes all 16 pool entries, mode 0 or a bad
// range goes straight to output. One transaction at a time. Synchronous reset
// clears pool (by valid bits), index and control state; config takes defaults.
// ----------------------------------------------------------------------------
module well512_sector_count_generator_unit
  import wscg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  wscg_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output wscg_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [3:0]  mode_r;
  logic [15:0] min_r, max_r;

  // sequencer and datapath registers
  wscg_state_t state_r, state_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [31:0] seed_r, seed_nxt;
  logic [31:0] a_r, a_nxt;
  logic [31:0] b_r, b_nxt;
  logic [31:0] c_r, c_nxt;
  logic [31:0] d_r, d_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [DivW-1:0] div_r, div_nxt;
  logic [DivW-1:0] rem_r, rem_nxt;
  logic [3:0]  dmode_r, dmode_nxt;
  wscg_out_t   res_r, res_nxt;
  wscg_out_t   out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  // pool memory with per-entry valid bits
  logic [31:0] pool_mem [16];
  logic [15:0] pool_vld_r, pool_vld_nxt;
  logic [31:0] rd_data_r;
  logic        rd_vld_r;
  logic [3:0]  rd_addr;
  logic        wr_en;
  logic [3:0]  wr_addr;
  logic [31:0] wr_data;
  logic [31:0] rd_val;

  // misc combinational values
  logic        bad_range;
  logic [15:0] span;
  logic [DivW-1:0] slots;
  logic [DivW:0]   trial;
  logic        trial_ge;
  logic [31:0] c_mix, a_new, d_new, f_new;
  logic [15:0] q16;
  logic [15:0] cnt;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_MIX120;
      min_r  <= 16'd8;
      max_r  <= 16'd512;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE: mode_r <= cfg_data[3:0];
        REG_MIN:  min_r  <= cfg_data;
        REG_MAX:  max_r  <= cfg_data;
        default:  ;
      endcase
    end
  end

  // pool memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pool_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= pool_mem[rd_addr];
  end

  assign rd_val = rd_vld_r ? rd_data_r : 32'd0;

  // mode 8 bound check and slot count
  assign bad_range = (min_r < 16'(SectorUnit)) || (max_r <= 16'(SectorUnit)) ||
                     (min_r >= max_r);
  assign span  = max_r - min_r;
  assign slots = DivW'(span >> 3) + DivW'(1);

  // shared divider step
  assign trial    = {rem_r, dvd_r[31]};
  assign trial_ge = (trial >= {1'b0, div_r});

  // generator datapath
  assign c_mix = rd_val ^ (rd_val >> 11);
  assign a_new = b_r ^ c_mix;
  assign d_new = a_new ^ ((a_new << 5) & TEMPER_MASK);
  assign f_new = rd_val ^ b_r ^ d_r ^ (rd_val << 2) ^ (b_r << 18) ^ (c_r << 28);

  // remainder to sector count
  assign q16 = 16'(rem_r);
  always_comb begin
    cnt = 16'd0;
    case (dmode_r) inside
      MODE_MIX120: begin
        if (q16 < 16'd15)      cnt = 16'd8;
        else if (q16 < 16'd30) cnt = 16'd16;
        else if (q16 < 16'd45) cnt = 16'd24;
        else if (q16 < 16'd60) cnt = 16'd32;
        else if (q16 < 16'd61) cnt = 16'd40;
        else                   cnt = ((q16 - 16'd60) << 3) + 16'd40;
      end
      MODE_MIX336: begin
        if (q16 < 16'd21)      cnt = 16'd8;
        else if (q16 < 16'd42) cnt = 16'd16;
        else if (q16 < 16'd63) cnt = 16'd24;
        else if (q16 < 16'd84) cnt = 16'd32;
        else if (q16 < 16'd85) cnt = 16'd40;
        else                   cnt = ((q16 - 16'd84) << 3) + 16'd40;
      end
      MODE_SPAN57, MODE_SPN121: cnt = (q16 << 3) + 16'd64;
      MODE_SPAN64, MODE_SPN128: cnt = (q16 << 3) + 16'(SectorUnit);
      MODE_POW35: begin
        if (q16 < 16'd28) cnt = 16'd8;
        else              cnt = 16'd16 << q16[2:0] - 3'd4;
      end
      MODE_RANGE: cnt = (q16 << 3) + min_r;
      default:    cnt = 16'd0;
    endcase
  end

  // sequencer: next state, datapath and memory controls
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    seed_nxt      = seed_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    dvd_nxt       = dvd_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    dmode_nxt     = dmode_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    pool_vld_nxt  = pool_vld_r;
    rd_addr       = idx_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = a_new;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          dmode_nxt = mode_r;
          res_nxt   = '0;
          if (in_data.action == ACT_SEED) begin
            seed_nxt  = in_data.seed;
            step_nxt  = 5'd0;
            state_nxt = ST_SEED;
          end else begin
            case (mode_r) inside
              MODE_MIX120, MODE_SPAN57, MODE_MIX336, MODE_SPN121,
              MODE_SPAN64, MODE_SPN128, MODE_POW35: begin
                state_nxt = ST_GET_A;
              end
              MODE_RANGE: begin
                if (bad_range) begin
                  res_nxt.sector_count = 16'(SectorUnit);
                  res_nxt.range_error  = 1'b1;
                  state_nxt            = ST_OUT;
                end else begin
                  state_nxt = ST_GET_A;
                end
              end
              default: state_nxt = ST_OUT;
            endcase
            case (mode_r)
              MODE_MIX120: div_nxt = DivW'(120);
              MODE_SPAN57: div_nxt = DivW'(57);
              MODE_MIX336: div_nxt = DivW'(336);
              MODE_SPN121: div_nxt = DivW'(121);
              MODE_SPAN64: div_nxt = DivW'(64);
              MODE_SPN128: div_nxt = DivW'(128);
              MODE_POW35:  div_nxt = DivW'(35);
              default:     div_nxt = slots;
            endcase
          end
        end
      end

      // fill the pool one entry a cycle
      ST_SEED: begin
        wr_en        = 1'b1;
        wr_addr      = step_r[3:0];
        wr_data      = seed_r;
        pool_vld_nxt = pool_vld_r | (16'd1 << step_r[3:0]);
        seed_nxt     = {seed_r[30:0], 1'b0} + SEED_STEP;
        step_nxt     = step_r + 5'd1;
        if (step_r[3:0] == 4'd15) begin
          idx_nxt   = 4'd0;
          state_nxt = ST_IDLE;
        end
      end

      // pool[i] arrives, fetch pool[i+13]
      ST_GET_A: begin
        a_nxt     = rd_val;
        rd_addr   = idx_r + 4'd13;
        state_nxt = ST_GET_C;
      end

      // pool[i+13] arrives, fetch pool[i+9]
      ST_GET_C: begin
        b_nxt     = a_r ^ rd_val ^ (a_r << 16) ^ (rd_val << 15);
        rd_addr   = idx_r + 4'd9;
        state_nxt = ST_GET_E;
      end

      // pool[i+9] arrives, update pool[i], fetch pool[i-1]
      ST_GET_E: begin
        c_nxt        = c_mix;
        d_nxt        = d_new;
        wr_en        = 1'b1;
        wr_addr      = idx_r;
        wr_data      = a_new;
        pool_vld_nxt = pool_vld_r | (16'd1 << idx_r);
        rd_addr      = idx_r - 4'd1;
        state_nxt    = ST_GET_F;
      end

      // pool[i-1] arrives, update it, produce the raw word and step the index back
      ST_GET_F: begin
        wr_en             = 1'b1;
        wr_addr           = idx_r - 4'd1;
        wr_data           = f_new;
        pool_vld_nxt      = pool_vld_r | (16'd1 << (idx_r - 4'd1));
        idx_nxt           = idx_r - 4'd1;
        res_nxt.rand_word = f_new;
        dvd_nxt           = f_new;
        rem_nxt           = '0;
        step_nxt          = 5'd0;
        state_nxt         = ST_DIV;
      end

      // restoring division, one quotient bit a cycle
      ST_DIV: begin
        rem_nxt  = trial_ge ? DivW'(trial - {1'b0, div_r}) : DivW'(trial);
        dvd_nxt  = {dvd_r[30:0], 1'b0};
        step_nxt = step_r + 5'd1;
        if (step_r == 5'd31) begin
          state_nxt = ST_MAP;
        end
      end

      ST_MAP: begin
        res_nxt.sector_count = cnt;
        state_nxt            = ST_OUT;
      end

      // hand the result to the output register once it is free
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= 4'd0;
      step_r      <= 5'd0;
      out_valid_r <= 1'b0;
      pool_vld_r  <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      pool_vld_r  <= pool_vld_nxt;
      rd_vld_r    <= pool_vld_r[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    seed_r  <= seed_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    c_r     <= c_nxt;
    d_r     <= d_nxt;
    dvd_r   <= dvd_nxt;
    div_r   <= div_nxt;
    rem_r   <= rem_nxt;
    dmode_r <= dmode_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

endmodule
